FILE: rtl/core/rgbaoc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the rgba over compositor
// no dependencies; used by every file under rtl/core
package rgbaoc_pkg;

	localparam int unsigned CHAN_W             = 8;
	localparam int unsigned PROD_W             = 2 * CHAN_W;
	localparam int unsigned CHANNEL_MAX        = 255;
	localparam int unsigned HALF               = CHANNEL_MAX / 2;
	localparam int unsigned NUM_COLORS         = 3;
	localparam int unsigned QUO_BITS_PER_STAGE = 2;
	localparam int unsigned QUO_STAGES         = CHAN_W / QUO_BITS_PER_STAGE;
	localparam int unsigned BLEND_STAGES       = 6;
	// blend stages, divider entry stage, divider step stages
	localparam int unsigned PIPE_DEPTH         = BLEND_STAGES + QUO_STAGES + 1;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PROD_W-1:0] prod_t;

	// color[2] red, color[1] green, color[0] blue
	typedef logic [NUM_COLORS-1:0][CHAN_W-1:0] color_t;

	typedef struct packed {
		color_t color;
		chan_t  alpha;
	} pixel_t;

	typedef enum logic [1:0] {
		MODE_BLEND = 2'd0,
		MODE_DST   = 2'd1,
		MODE_SRC   = 2'd2
	} mode_t;

	// request into the un-premultiply divider
	typedef struct packed {
		pixel_t pix;
		logic   nodiv;
	} unpm_req_t;

endpackage

FILE: rtl/core/rgbaoc_unpremul.sv
`timescale 1ns / 1ps
// un-premultiply stage: floor(c * 255 / alpha) per color, saturated at 255
// pipelined restoring divider, two quotient bits per stage; uses rgbaoc_pkg
module rgbaoc_unpremul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rgbaoc_pkg::unpm_req_t req,
	output logic                res_valid,
	input  logic                res_ready,
	output rgbaoc_pkg::pixel_t  res
);

	localparam int unsigned QS = rgbaoc_pkg::QUO_STAGES;
	localparam int unsigned NC = rgbaoc_pkg::NUM_COLORS;
	localparam int unsigned CW = rgbaoc_pkg::CHAN_W;

	// one restoring step: shift in next numerator bit, subtract if it fits
	function automatic logic [3*CW-1:0] div_step(
		input rgbaoc_pkg::chan_t d,
		input rgbaoc_pkg::chan_t r,
		input rgbaoc_pkg::chan_t l,
		input rgbaoc_pkg::chan_t q
	);
		logic [CW:0] t;
		t = {r, l[CW-1]};
		if (t >= {1'b0, d}) begin
			return {rgbaoc_pkg::chan_t'(t - {1'b0, d}), l << 1, q[CW-2:0], 1'b1};
		end else begin
			return {t[CW-1:0], l << 1, q[CW-2:0], 1'b0};
		end
	endfunction

	logic                   v_s     [0:QS];
	logic                   en      [0:QS];
	logic                   v_n     [0:QS];
	rgbaoc_pkg::color_t     rem_s   [0:QS];
	rgbaoc_pkg::color_t     low_s   [0:QS];
	rgbaoc_pkg::color_t     quo_s   [0:QS];
	logic [NC-1:0]          sat_s   [0:QS];
	rgbaoc_pkg::pixel_t     pix_s   [0:QS];
	logic                   nodiv_s [0:QS];
	rgbaoc_pkg::color_t     rem_n   [0:QS];
	rgbaoc_pkg::color_t     low_n   [0:QS];
	rgbaoc_pkg::color_t     quo_n   [0:QS];
	logic [NC-1:0]          sat_n   [0:QS];
	rgbaoc_pkg::pixel_t     pix_n   [0:QS];
	logic                   nodiv_n [0:QS];

	// a stage takes new data when empty or when the one after it moves
	always_comb begin
		en[QS] = !v_s[QS] || res_ready;
		for (int k = QS - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign req_ready = en[0];

	// entry stage: numerator c * 255, saturation check against alpha * 256
	always_comb begin
		rgbaoc_pkg::prod_t n;
		v_n[0]     = req_valid;
		pix_n[0]   = req.pix;
		nodiv_n[0] = req.nodiv;
		for (int i = 0; i < NC; i++) begin
			n = {req.pix.color[i], {CW{1'b0}}} - rgbaoc_pkg::prod_t'(req.pix.color[i]);
			sat_n[0][i] = n[2*CW-1:CW] >= req.pix.alpha;
			rem_n[0][i] = n[2*CW-1:CW];
			low_n[0][i] = n[CW-1:0];
			quo_n[0][i] = '0;
		end
	end

	for (genvar k = 1; k <= QS; k++) begin : g_step
		always_comb begin
			rgbaoc_pkg::color_t r, l, q;
			r = rem_s[k-1];
			l = low_s[k-1];
			q = quo_s[k-1];
			for (int i = 0; i < NC; i++) begin
				for (int b = 0; b < rgbaoc_pkg::QUO_BITS_PER_STAGE; b++) begin
					{r[i], l[i], q[i]} = div_step(pix_s[k-1].alpha, r[i], l[i], q[i]);
				end
			end
			v_n[k]     = v_s[k-1];
			rem_n[k]   = r;
			low_n[k]   = l;
			quo_n[k]   = q;
			sat_n[k]   = sat_s[k-1];
			pix_n[k]   = pix_s[k-1];
			nodiv_n[k] = nodiv_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QS; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k <= QS; k++) begin
				if (en[k]) begin
					v_s[k] <= v_n[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= QS; k++) begin
			if (en[k]) begin
				rem_s[k]   <= rem_n[k];
				low_s[k]   <= low_n[k];
				quo_s[k]   <= quo_n[k];
				sat_s[k]   <= sat_n[k];
				pix_s[k]   <= pix_n[k];
				nodiv_s[k] <= nodiv_n[k];
			end
		end
	end

	assign res_valid = v_s[QS];

	always_comb begin
		res.alpha = pix_s[QS].alpha;
		for (int i = 0; i < NC; i++) begin
			if (nodiv_s[QS]) begin
				res.color[i] = pix_s[QS].color[i];
			end else if (sat_s[QS][i]) begin
				res.color[i] = rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX);
			end else begin
				res.color[i] = quo_s[QS][i];
			end
		end
	end

endmodule

FILE: rtl/core/rgba_over_composite_top.sv
`timescale 1ns / 1ps
// rgba over compositor top level: blend pipeline plus un-premultiply divider
// depends on rgbaoc_pkg and rgbaoc_unpremul
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_ready  | src_red..src_alpha, dst_red..dst_alpha
//   out     | out_valid / out_ready| out_red, out_green, out_blue, out_alpha
//   cfg     | cfg_wr_en            | cfg_wr_data (layer opacity)
//
// one pixel per cycle sustained while out_ready stays high; every stage is registered
// six blend stages (multiplies and divide-by-255) then five divider stages:
// an entry stage and four restoring steps of two quotient bits each
// reset clears all valid bits and sets the opacity to 255
// each stage holds while it is full and its successor cannot take data, so bubbles close up under a stall
module rgba_over_composite_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  rgbaoc_pkg::chan_t         cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rgbaoc_pkg::chan_t         src_red,
	input  rgbaoc_pkg::chan_t         src_green,
	input  rgbaoc_pkg::chan_t         src_blue,
	input  rgbaoc_pkg::chan_t         src_alpha,
	input  rgbaoc_pkg::chan_t         dst_red,
	input  rgbaoc_pkg::chan_t         dst_green,
	input  rgbaoc_pkg::chan_t         dst_blue,
	input  rgbaoc_pkg::chan_t         dst_alpha,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rgbaoc_pkg::chan_t         out_red,
	output rgbaoc_pkg::chan_t         out_green,
	output rgbaoc_pkg::chan_t         out_blue,
	output rgbaoc_pkg::chan_t         out_alpha
);

	localparam int unsigned NC = rgbaoc_pkg::NUM_COLORS;
	localparam int unsigned CW = rgbaoc_pkg::CHAN_W;
	localparam int unsigned PW = rgbaoc_pkg::PROD_W;

	// x / 255 for x below 2^16 as (x + (x >> 8) + 1) >> 8, saturated at 255
	function automatic rgbaoc_pkg::chan_t div_cmax(input rgbaoc_pkg::prod_t x);
		logic [PW:0] t;
		t = {1'b0, x} + (PW+1)'(x[PW-1:CW]) + (PW+1)'(1);
		if (t[PW]) begin
			return rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX);
		end else begin
			return t[PW-1:CW];
		end
	endfunction

	function automatic rgbaoc_pkg::prod_t mul8(
		input rgbaoc_pkg::chan_t a,
		input rgbaoc_pkg::chan_t b
	);
		return rgbaoc_pkg::prod_t'(a) * rgbaoc_pkg::prod_t'(b);
	endfunction

	rgbaoc_pkg::chan_t     opacity_q;
	rgbaoc_pkg::pixel_t    src_pix, dst_pix;
	rgbaoc_pkg::mode_t     mode_d;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                  en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic                  req_ready;

	rgbaoc_pkg::pixel_t    src_s1, src_s2, src_s3, src_s4, src_s5;
	rgbaoc_pkg::pixel_t    dst_s1, dst_s2, dst_s3, dst_s4, dst_s5;
	rgbaoc_pkg::mode_t     mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	rgbaoc_pkg::prod_t     prod_s1;
	rgbaoc_pkg::chan_t     esa_s2, esa_s3, esa_s4;
	rgbaoc_pkg::prod_t     dainv_s3;
	rgbaoc_pkg::chan_t     dw_s4;
	rgbaoc_pkg::chan_t     a_s4, a_s5;
	rgbaoc_pkg::prod_t     sum_s5 [NC];
	rgbaoc_pkg::prod_t     sum_d  [NC];
	rgbaoc_pkg::unpm_req_t req_s6, req_d;
	rgbaoc_pkg::pixel_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX);
		end else if (cfg_wr_en) begin
			opacity_q <= cfg_wr_data;
		end
	end

	assign src_pix = rgbaoc_pkg::pixel_t'({src_red, src_green, src_blue, src_alpha});
	assign dst_pix = rgbaoc_pkg::pixel_t'({dst_red, dst_green, dst_blue, dst_alpha});

	// pass-through cases only at zero or full opacity
	always_comb begin
		priority if (opacity_q == '0) begin
			mode_d = rgbaoc_pkg::MODE_DST;
		end else if (opacity_q == rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX)) begin
			priority if (src_alpha == '0) begin
				mode_d = rgbaoc_pkg::MODE_DST;
			end else if (dst_alpha == '0 ||
			             src_alpha == rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX)) begin
				mode_d = rgbaoc_pkg::MODE_SRC;
			end else begin
				mode_d = rgbaoc_pkg::MODE_BLEND;
			end
		end else begin
			mode_d = rgbaoc_pkg::MODE_BLEND;
		end
	end

	// per-stage flow control
	assign en_s6    = !v_s6 || req_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// blended colors: (dst_c * dst_weight + src_c * eff_alpha + 127) summed per lane
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			sum_d[i] = mul8(dst_s4.color[i], dw_s4) + mul8(src_s4.color[i], esa_s4)
			         + rgbaoc_pkg::prod_t'(rgbaoc_pkg::HALF);
		end
	end

	always_comb begin
		req_d = '0;
		unique case (mode_s5)
			rgbaoc_pkg::MODE_DST: begin
				req_d.pix   = dst_s5;
				req_d.nodiv = 1'b1;
			end
			rgbaoc_pkg::MODE_SRC: begin
				req_d.pix   = src_s5;
				req_d.nodiv = 1'b1;
			end
			rgbaoc_pkg::MODE_BLEND: begin
				for (int i = 0; i < NC; i++) begin
					req_d.pix.color[i] = div_cmax(sum_s5[i]);
				end
				req_d.pix.alpha = a_s5;
				req_d.nodiv     = (a_s5 == '0);
			end
			default: begin
				req_d.pix   = dst_s5;
				req_d.nodiv = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			src_s1  <= src_pix;
			dst_s1  <= dst_pix;
			mode_s1 <= mode_d;
			prod_s1 <= mul8(src_alpha, opacity_q);
		end
		if (en_s2) begin
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			mode_s2 <= mode_s1;
			esa_s2  <= div_cmax(prod_s1 + rgbaoc_pkg::prod_t'(rgbaoc_pkg::HALF));
		end
		if (en_s3) begin
			src_s3   <= src_s2;
			dst_s3   <= dst_s2;
			mode_s3  <= mode_s2;
			esa_s3   <= esa_s2;
			dainv_s3 <= mul8(dst_s2.alpha,
			                 rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX) - esa_s2);
		end
		if (en_s4) begin
			src_s4  <= src_s3;
			dst_s4  <= dst_s3;
			mode_s4 <= mode_s3;
			esa_s4  <= esa_s3;
			dw_s4   <= div_cmax(dainv_s3 + rgbaoc_pkg::prod_t'(rgbaoc_pkg::HALF));
			a_s4    <= div_cmax(dainv_s3
			                    + mul8(esa_s3, rgbaoc_pkg::chan_t'(rgbaoc_pkg::CHANNEL_MAX))
			                    + rgbaoc_pkg::prod_t'(rgbaoc_pkg::HALF));
		end
		if (en_s5) begin
			src_s5  <= src_s4;
			dst_s5  <= dst_s4;
			mode_s5 <= mode_s4;
			a_s5    <= a_s4;
			sum_s5  <= sum_d;
		end
		if (en_s6) begin
			req_s6  <= req_d;
		end
	end

	rgbaoc_unpremul u_unpremul (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s6),
		.req_ready (req_ready),
		.req       (req_s6),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign out_red   = res.color[2];
	assign out_green = res.color[1];
	assign out_blue  = res.color[0];
	assign out_alpha = res.alpha;

endmodule

FILE: rtl/core/rgbaoc_chk.sv
`timescale 1ns / 1ps
// port-level checks for rgba_over_composite_top, attached by bind below
// depends on rgbaoc_pkg for the pipeline depth
module rgbaoc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input rgbaoc_pkg::chan_t out_red,
	input rgbaoc_pkg::chan_t out_green,
	input rgbaoc_pkg::chan_t out_blue,
	input rgbaoc_pkg::chan_t out_alpha
);

	localparam int unsigned CNT_W = $clog2(rgbaoc_pkg::PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_xact, out_xact;

	assign in_xact  = in_valid && in_ready;
	assign out_xact = out_valid && out_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xact && !out_xact) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_xact && !in_xact) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha))
		else $error("output changed while stalled");

	a_ready_when_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output can drain");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result shown with no transaction in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(rgbaoc_pkg::PIPE_DEPTH))
		else $error("more transactions in flight than pipeline stages");

endmodule

bind rgba_over_composite_top rgbaoc_chk u_rgbaoc_chk (.*);
